// ----- hw/rtl/ptmap_pkg.sv -----
// Shared types and constants for the four-level page table mapper.
// No dependencies; imported by every module of the block.
package ptmap_pkg;

  localparam int ENTRIES_PER_LEVEL = 512;
  localparam int IDX_W             = 9;
  localparam int ENTRY_W           = 64;
  localparam int FRAME_W           = 40;
  localparam int CFG_IDX_W         = 2;

  localparam logic [ENTRY_W-1:0] ADDR_MASK   = 64'h000F_FFFF_FFFF_F000;
  localparam logic [ENTRY_W-1:0] BIT_PRESENT = 64'h0000_0000_0000_0001;
  localparam logic [ENTRY_W-1:0] BIT_HUGE    = 64'h0000_0000_0000_0080;
  localparam logic [11:0]        LINK_FLAGS  = 12'h003;  // present | writable

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_READY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = 2'd1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_READY = 3'd1,
    ST_MISALIGNED = 3'd2,
    ST_HUGE      = 3'd3,
    ST_EXHAUSTED = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    WS_IDLE,
    WS_READ,
    WS_EVAL,
    WS_LEAF,
    WS_FINISH
  } walk_state_t;

endpackage

// ----- hw/rtl/four_level_page_table_mapper.sv -----
// Top level of the four-level page table mapper: configuration registers,
// table store and walk sequencer. Depends on ptmap_pkg, ptmap_store, ptmap_walk.
//
// Channel   Dir  Beat fields (lowest bit up)
// s_axis    in   tdata: virt_addr[63:0], phys_addr[127:64], entry_flags[191:128]
// m_axis    out  tdata: status[2:0], leaf_entry[66:3], invalidate_page[118:67],
//                       tables_used[125:119], zero pad[127:126]
// cfg       in   cfg_index 0 root_ready (bit 0), 1 pool_base_frame (bits 39:0)
//
// Steps: a rejected request goes from accept straight to result load; a full walk runs
//   accept, three read/evaluate pairs on the single store port, leaf write, result load.
// Reset: after rst the store is swept to zero one entry a cycle, over all
//   TABLE_PAGES*512 entries (32768 at the default); s_axis_tready stays low then.
// Stalls: a finished result waits in the output register; the walker holds in
//   its final step until m_axis_tready frees it. cfg is always ready.
module four_level_page_table_mapper #(
  parameter int TABLE_PAGES = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [191:0] s_axis_tdata,   // virt_addr, phys_addr, entry_flags
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata,   // status, leaf_entry, invalidate_page, tables_used
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [ptmap_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ptmap_pkg::FRAME_W-1:0]   cfg_data
);
  import ptmap_pkg::*;

  localparam int AW = $clog2(TABLE_PAGES) + IDX_W;

  logic               root_ready;
  logic [FRAME_W-1:0] pool_base;
  logic               clearing;
  logic [AW-1:0]      mem_addr;
  logic               mem_we;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [ENTRY_W-1:0] mem_rdata;

  assign cfg_ready = 1'b1;

  // configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      root_ready <= 1'b0;
      pool_base  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROOT_READY: root_ready <= cfg_data[0];
        CFG_POOL_BASE:  pool_base  <= cfg_data;
        default: ;
      endcase
    end
  end

  ptmap_store #(
    .TABLE_PAGES (TABLE_PAGES)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .addr     (mem_addr),
    .we       (mem_we),
    .wdata    (mem_wdata),
    .rdata    (mem_rdata),
    .clearing (clearing)
  );

  ptmap_walk #(
    .TABLE_PAGES (TABLE_PAGES)
  ) u_walk (
    .clk           (clk),
    .rst           (rst),
    .clearing      (clearing),
    .root_ready    (root_ready),
    .pool_base     (pool_base),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mem_addr      (mem_addr),
    .mem_we        (mem_we),
    .mem_wdata     (mem_wdata),
    .mem_rdata     (mem_rdata)
  );

endmodule

// ----- hw/rtl/ptmap_store.sv -----
// Table store: single-port synchronous RAM of 64-bit entries with a registered read.
// Sweeps itself to zero after reset. Depends on ptmap_pkg.
module ptmap_store #(
  parameter int TABLE_PAGES = 64
) (
  input  logic                                                   clk,
  input  logic                                                   rst,
  input  logic [$clog2(TABLE_PAGES)+ptmap_pkg::IDX_W-1:0]        addr,
  input  logic                                                   we,
  input  logic [ptmap_pkg::ENTRY_W-1:0]                          wdata,
  output logic [ptmap_pkg::ENTRY_W-1:0]                          rdata,
  output logic                                                   clearing
);
  import ptmap_pkg::*;

  localparam int DEPTH = TABLE_PAGES * ENTRIES_PER_LEVEL;
  localparam int AW    = $clog2(TABLE_PAGES) + IDX_W;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [AW-1:0]      clr_addr;
  logic [AW-1:0]      wr_addr;
  logic               wr_en;
  logic [ENTRY_W-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // clear sweep owns the write port
  assign wr_addr = clearing ? clr_addr : addr;
  assign wr_en   = clearing | we;
  assign wr_data = clearing ? '0 : wdata;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- hw/rtl/ptmap_walk.sv -----
// Walk sequencer: reads, checks and links the three intermediate levels,
// writes the leaf, holds the bump allocator and the result register.
// Depends on ptmap_pkg; drives the ptmap_store port.
module ptmap_walk #(
  parameter int TABLE_PAGES = 64
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             clearing,
  input  logic                                             root_ready,
  input  logic [ptmap_pkg::FRAME_W-1:0]                    pool_base,
  input  logic                                             s_axis_tvalid,
  output logic                                             s_axis_tready,
  input  logic [191:0]                                     s_axis_tdata,
  output logic                                             m_axis_tvalid,
  input  logic                                             m_axis_tready,
  output logic [127:0]                                     m_axis_tdata,
  output logic [$clog2(TABLE_PAGES)+ptmap_pkg::IDX_W-1:0]  mem_addr,
  output logic                                             mem_we,
  output logic [ptmap_pkg::ENTRY_W-1:0]                    mem_wdata,
  input  logic [ptmap_pkg::ENTRY_W-1:0]                    mem_rdata
);
  import ptmap_pkg::*;

  localparam int PGW = $clog2(TABLE_PAGES);
  localparam int NW  = $clog2(TABLE_PAGES + 1);

  walk_state_t        state;
  walk_state_t        state_next;
  logic [63:0]        va;
  logic [63:0]        pa;
  logic [63:0]        fl;
  logic [PGW-1:0]     page;
  logic [1:0]         level;
  logic [NW-1:0]      nfp;
  status_t            st;

  logic [IDX_W-1:0]   idx;
  logic [FRAME_W-1:0] rel;
  logic [FRAME_W-1:0] link_frame;
  logic [ENTRY_W-1:0] link;
  logic [ENTRY_W-1:0] leaf;
  logic               pool_full;
  logic               rel_bad;
  logic               misaligned;
  logic               accept;
  logic               out_load;

  // level 3 selects the leaf index
  always_comb begin
    case (level)
      2'd0:    idx = va[47:39];
      2'd1:    idx = va[38:30];
      2'd2:    idx = va[29:21];
      default: idx = va[20:12];
    endcase
  end

  assign mem_addr   = {page, idx};
  assign rel        = mem_rdata[51:12] - pool_base;
  assign rel_bad    = rel >= FRAME_W'(TABLE_PAGES);
  assign link_frame = pool_base + FRAME_W'(nfp);
  assign link       = {12'h000, link_frame, LINK_FLAGS};
  assign leaf       = ((pa & ADDR_MASK) | fl | BIT_PRESENT) & ~BIT_HUGE;
  assign pool_full  = nfp >= NW'(TABLE_PAGES);
  assign misaligned = (s_axis_tdata[11:0] | s_axis_tdata[75:64]) != 12'h000;
  assign accept     = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= WS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    mem_we        = 1'b0;
    mem_wdata     = link;
    out_load      = 1'b0;
    case (state)
      WS_IDLE: begin
        s_axis_tready = !clearing;
        if (s_axis_tvalid && !clearing) begin
          state_next = (root_ready && !misaligned) ? WS_READ : WS_FINISH;
        end
      end
      WS_READ: begin
        state_next = WS_EVAL;
      end
      WS_EVAL: begin
        if (mem_rdata[0]) begin
          if (mem_rdata[7] || rel_bad) begin
            state_next = WS_FINISH;
          end else begin
            state_next = (level == 2'd2) ? WS_LEAF : WS_READ;
          end
        end else if (pool_full) begin
          state_next = WS_FINISH;
        end else begin
          mem_we     = 1'b1;
          state_next = (level == 2'd2) ? WS_LEAF : WS_READ;
        end
      end
      WS_LEAF: begin
        mem_we     = 1'b1;
        mem_wdata  = leaf;
        state_next = WS_FINISH;
      end
      WS_FINISH: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load   = 1'b1;
          state_next = WS_IDLE;
        end
      end
      default: begin
        state_next = WS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nfp           <= NW'(1);
      m_axis_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (state == WS_EVAL && !mem_rdata[0] && !pool_full) begin
        nfp <= nfp + 1'b1;
      end
    end
  end

  // payload and walk position
  always_ff @(posedge clk) begin
    if (accept) begin
      va    <= s_axis_tdata[63:0];
      pa    <= s_axis_tdata[127:64];
      fl    <= s_axis_tdata[191:128];
      level <= 2'd0;
      page  <= '0;
      if (!root_ready) begin
        st <= ST_NOT_READY;
      end else if (misaligned) begin
        st <= ST_MISALIGNED;
      end else begin
        st <= ST_OK;
      end
    end
    if (state == WS_EVAL) begin
      if (mem_rdata[0]) begin
        if (mem_rdata[7]) begin
          st <= ST_HUGE;
        end else if (rel_bad) begin
          st <= ST_EXHAUSTED;
        end else begin
          page  <= rel[PGW-1:0];
          level <= level + 1'b1;
        end
      end else if (pool_full) begin
        st <= ST_EXHAUSTED;
      end else begin
        page  <= nfp[PGW-1:0];
        level <= level + 1'b1;
      end
    end
    if (out_load) begin
      m_axis_tdata <= {2'b00, 7'(nfp),
                       (st == ST_OK) ? va[63:12] : 52'd0,
                       (st == ST_OK) ? leaf : 64'd0,
                       st};
    end
  end

  a_nfp_range: assert property (@(posedge clk) disable iff (rst)
    (nfp != '0) && (nfp <= NW'(TABLE_PAGES)))
    else $error("allocator count out of range");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!mem_we && !s_axis_tready))
    else $error("walker active during store clear");

  a_leaf_bits: assert property (@(posedge clk) disable iff (rst)
    (out_load && st == ST_OK) |=> (m_axis_tdata[3] && !m_axis_tdata[10]))
    else $error("successful leaf without present or with huge bit");

  a_nfp_step: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> (nfp == $past(nfp) || nfp == NW'($past(nfp) + 1'b1)))
    else $error("allocator moved by more than one page");

endmodule

// ----- tb/testbench.sv -----
// Self-checking bench for four_level_page_table_mapper: directed table, then random
// map requests under three idling mixes, checked against an in-bench table walker.
// Depends on ptmap_pkg and the RTL of the block only.
module testbench;
  import ptmap_pkg::*;

  localparam int TABLE_PAGES = 64;
  localparam int CYCLE_LIMIT = 400_000;   // covers the store sweep plus a slow run, many times over
  localparam int STALL_CYCLES = 300;      // long receiver hold-off, fills the block
  localparam int SETTLE_CYCLES = 16;      // quiet time before a register write or the verdict

  // Register indexes the block does not decode; writes to them must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

  typedef struct packed {
    status_t     status;
    logic [63:0] leaf_entry;
    logic [51:0] invalidate_page;
    logic [6:0]  tables_used;
  } map_result_t;

  // One row of the directed table: a register write or a map request
  typedef struct {
    bit                   is_reg;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [FRAME_W-1:0]   reg_value;
    logic [63:0]          virt_addr;
    logic [63:0]          phys_addr;
    logic [63:0]          entry_flags;
    bit                   typed;      // expected result written into the row
    map_result_t          typed_result;
  } map_row_t;

  logic         clk = 1'b0;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata;   // virt_addr[63:0], phys_addr[127:64], entry_flags[191:128]
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [127:0] m_axis_tdata;   // status[2:0], leaf_entry[66:3], invalidate_page[118:67],
                                // tables_used[125:119], pad[127:126]
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [FRAME_W-1:0]   cfg_data;

  four_level_page_table_mapper #(.TABLE_PAGES(TABLE_PAGES)) uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the block: table store, bump allocator and registers
  bit [63:0]          pt_shadow [0:TABLE_PAGES*ENTRIES_PER_LEVEL-1];
  int unsigned        shadow_next_free = 1;   // page 0 is the root
  bit                 shadow_ready = 1'b0;
  logic [FRAME_W-1:0] shadow_base = '0;

  map_result_t expected_maps[$];   // results still owed by the block, oldest first
  map_row_t    directed_rows[$];
  logic [26:0] known_prefixes[$];  // va bits 47:21 already walked, reused to hit built tables

  int  map_errors = 0;
  int  cycle_count = 0;
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  stall_trigger = 1'b0;

  // One level of the walk: follow a present link or allocate and link a fresh table
  function automatic status_t walk_level(input int unsigned page, input logic [8:0] idx,
                                         output int unsigned child);
    int unsigned        slot;
    bit [63:0]          e;
    logic [FRAME_W-1:0] rel;
    slot  = page * ENTRIES_PER_LEVEL + idx;
    e     = pt_shadow[slot];
    child = 0;
    if (e[0]) begin
      if (e[7]) return ST_HUGE;
      rel = e[51:12] - shadow_base;   // wraps mod 2^40
      if (rel >= FRAME_W'(TABLE_PAGES)) return ST_EXHAUSTED;   // link outside the pool
      child = 32'(rel);
      return ST_OK;
    end
    if (shadow_next_free >= TABLE_PAGES) return ST_EXHAUSTED;   // pool full
    child = shadow_next_free;
    shadow_next_free++;
    pt_shadow[slot] = {12'h000, FRAME_W'(shadow_base + child), LINK_FLAGS};
    return ST_OK;
  endfunction

  // Result of one map request; updates the shadow store as the block would
  function automatic map_result_t predict_map(input logic [63:0] va, pa, fl);
    map_result_t r;
    status_t     st;
    int unsigned page;
    int unsigned child;
    logic [8:0]  idx [3];
    r      = '0;
    idx[0] = va[47:39];
    idx[1] = va[38:30];
    idx[2] = va[29:21];
    page   = 0;
    st     = ST_OK;
    if (!shadow_ready) begin
      st = ST_NOT_READY;                       // tested ahead of alignment
    end else if ((va[11:0] | pa[11:0]) != 12'h000) begin
      st = ST_MISALIGNED;
    end else begin
      // tables taken before a failure stay linked
      for (int lvl = 0; lvl < 3 && st == ST_OK; lvl++) begin
        st   = walk_level(page, idx[lvl], child);
        page = child;
      end
      if (st == ST_OK) begin
        r.leaf_entry = ((pa & ADDR_MASK) | fl | BIT_PRESENT) & ~BIT_HUGE;
        pt_shadow[page * ENTRIES_PER_LEVEL + va[20:12]] = r.leaf_entry;
        r.invalidate_page = va[63:12];
      end
    end
    r.status      = st;
    r.tables_used = shadow_next_free[6:0];
    return r;
  endfunction

  function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FRAME_W-1:0] val);
    map_row_t row;
    row = '{default: '0};
    row.is_reg    = 1'b1;
    row.reg_index = idx;
    row.reg_value = val;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_map(input logic [63:0] va, pa, fl);
    map_row_t row;
    row = '{default: '0};
    row.virt_addr   = va;
    row.phys_addr   = pa;
    row.entry_flags = fl;
    directed_rows.push_back(row);
  endfunction

  function automatic void add_checked(input logic [63:0] va, pa, fl, input status_t st,
                                      input logic [63:0] leaf, input logic [51:0] inv,
                                      input logic [6:0] used);
    map_row_t row;
    row = '{default: '0};
    row.virt_addr    = va;
    row.phys_addr    = pa;
    row.entry_flags  = fl;
    row.typed        = 1'b1;
    row.typed_result = '{status: st, leaf_entry: leaf, invalidate_page: inv, tables_used: used};
    directed_rows.push_back(row);
  endfunction

  // Offer one request beat; called and left just after a falling edge.
  // valid stays high into the next beat when no gap is drawn.
  task automatic send_map(input logic [63:0] va, pa, fl, input bit typed,
                          input map_result_t typed_res);
    map_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {fl, pa, va};
    do @(posedge clk); while (!s_axis_tready);
    predicted = predict_map(va, pa, fl);
    expected_maps.push_back(typed ? typed_res : predicted);
    @(negedge clk);
  endtask

  // Register write with the block idle: drain all results, let it settle, then write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FRAME_W-1:0] val);
    s_axis_tvalid <= 1'b0;
    while (expected_maps.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_ROOT_READY) shadow_ready = val[0];
    else if (idx == CFG_POOL_BASE) shadow_base = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly well-formed requests over a small set of walked prefixes, so that most
  // beats reach the leaf; a share of fresh prefixes drives the pool to exhaustion.
  task automatic run_random(input int n, input int fresh_pct);
    logic [63:0] va;
    logic [63:0] pa;
    logic [63:0] fl;
    logic [26:0] prefix;
    int          r;
    for (int i = 0; i < n; i++) begin
      r  = $urandom_range(99);
      fl = {$urandom, $urandom};
      if (r < 10) begin
        // noise: raw addresses, nearly always misaligned
        va = {$urandom, $urandom};
        pa = {$urandom, $urandom};
      end else begin
        if (r < 10 + fresh_pct || known_prefixes.size() == 0) begin
          prefix = 27'($urandom);
          known_prefixes.push_back(prefix);
        end else if (r < 20 + fresh_pct) begin
          // new last-level table under an existing directory
          prefix = known_prefixes[$urandom_range(known_prefixes.size() - 1)];
          prefix[8:0] = 9'($urandom);
          known_prefixes.push_back(prefix);
        end else begin
          prefix = known_prefixes[$urandom_range(known_prefixes.size() - 1)];
        end
        va = {16'($urandom), prefix, 9'($urandom), 12'h000};
        pa = {$urandom, $urandom};
        pa[11:0] = 12'h000;
      end
      send_map(va, pa, fl, 1'b0, '0);
    end
  endtask

  // Receiver: random tready at the falling edge, plus one long hold-off on request
  initial begin : result_sink
    int  stall_left;
    bit  stall_started;
    stall_left    = 0;
    stall_started = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_trigger && !stall_started) begin
        stall_left    = STALL_CYCLES;
        stall_started = 1'b1;
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Result check at the rising edge, plus the run-time limit
  always @(posedge clk) begin : result_check
    map_result_t got;
    map_result_t want;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.status          = status_t'(m_axis_tdata[2:0]);
      got.leaf_entry      = m_axis_tdata[66:3];
      got.invalidate_page = m_axis_tdata[118:67];
      got.tables_used     = m_axis_tdata[125:119];
      if (expected_maps.size() == 0) begin
        if (map_errors < 10)
          $display("unexpected result beat: status %0d leaf %h inv %h used %0d",
                   got.status, got.leaf_entry, got.invalidate_page, got.tables_used);
        map_errors++;
      end else begin
        want = expected_maps.pop_front();
        if (got.status !== want.status || got.leaf_entry !== want.leaf_entry ||
            got.invalidate_page !== want.invalidate_page ||
            got.tables_used !== want.tables_used) begin
          if (map_errors < 10) begin
            $display("mismatch at cycle %0d", cycle_count);
            $display("  expected: status %0d leaf %h inv %h used %0d",
                     want.status, want.leaf_entry, want.invalidate_page, want.tables_used);
            $display("  actual:   status %0d leaf %h inv %h used %0d",
                     got.status, got.leaf_entry, got.invalidate_page, got.tables_used);
          end
          map_errors++;
        end
      end
    end
  end

  initial begin : stimulus
    logic [FRAME_W-1:0] base_a;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_ROOT_READY;
    cfg_data      = '0;

    // Directed table. Root not ready after reset, so the first rows fail first on that.
    add_checked(64'h0, 64'h0, 64'h0, ST_NOT_READY, 64'h0, 52'h0, 7'd1);
    add_checked(64'hFFF, 64'h1, '1, ST_NOT_READY, 64'h0, 52'h0, 7'd1);  // not ready beats misaligned
    add_reg(CFG_POOL_BASE, 40'h0);
    add_reg(CFG_ROOT_READY, 40'h1);
    add_checked(64'h1, 64'h0, 64'h0, ST_MISALIGNED, 64'h0, 52'h0, 7'd1);
    add_checked(64'h0, 64'h800, 64'h0, ST_MISALIGNED, 64'h0, 52'h0, 7'd1);
    // first full walk allocates three tables
    add_checked(64'h0, 64'h0, 64'h0, ST_OK, 64'h1, 52'h0, 7'd4);
    // all-ones extremes: huge bit cleared, top bits pass into the leaf
    add_checked(64'hFFFF_FFFF_FFFF_F000, 64'hFFFF_FFFF_FFFF_F000, '1, ST_OK,
                64'hFFFF_FFFF_FFFF_FF7F, 52'hF_FFFF_FFFF_FFFF, 7'd7);
    add_map(64'h0000_0000_0000_1000, 64'h1234_5678_9ABC_D000, 64'h80);
    add_map(64'h0000_0080_0000_0000, 64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000);
    add_reg(CFG_SPARE_2, '1);   // undecoded indexes change nothing
    add_reg(CFG_SPARE_3, '1);
    add_map(64'h0, 64'h0, 64'h7);
    add_reg(CFG_ROOT_READY, 40'hFF_FFFF_FFFE);   // only bit 0 counts
    add_map(64'h2000, 64'h0, 64'h0);
    add_reg(CFG_ROOT_READY, 40'h1);
    // top pool base: old links alias other pages, new links wrap the frame
    add_reg(CFG_POOL_BASE, 40'hFF_FFFF_FFFF);
    add_map(64'h0, 64'h0, 64'h0);
    add_map(64'h0000_0040_0020_0000, 64'h5555_5555_5555_5000, 64'hAAAA_AAAA_AAAA_AAAA);
    // links now point far outside the pool
    add_reg(CFG_POOL_BASE, 40'h80_0000_0000);
    add_map(64'h0, 64'h0, 64'h0);
    add_map(64'h0000_FF80_0000_0000, 64'h0, 64'h0);

    // phase 1 mix: sender rarely idle, receiver often
    send_idle_pct = 8;
    recv_idle_pct = 62;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_reg)
        write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
      else
        send_map(directed_rows[i].virt_addr, directed_rows[i].phys_addr,
                 directed_rows[i].entry_flags, directed_rows[i].typed,
                 directed_rows[i].typed_result);
    end

    // random, phase 1: fresh base, heavy allocation until the pool runs out
    base_a = FRAME_W'({$urandom, $urandom});
    write_reg(CFG_POOL_BASE, base_a);
    write_reg(CFG_ROOT_READY, 40'h1);
    run_random(180, 25);

    // phase 2: roles swapped; base nudged so existing links alias neighbouring pages
    write_reg(CFG_POOL_BASE, FRAME_W'(base_a + $urandom_range(1, 4)));
    send_idle_pct = 62;
    recv_idle_pct = 8;
    run_random(180, 10);

    // phase 3: no idling, base restored so the built tables walk again;
    // receiver holds off for a long stretch so the block backs up into its input
    write_reg(CFG_POOL_BASE, base_a);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_trigger = 1'b1;
    run_random(180, 10);

    s_axis_tvalid <= 1'b0;
    while (expected_maps.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (map_errors == 0 && expected_maps.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ----- four_level_page_table_mapper.f -----
hw/rtl/ptmap_pkg.sv
hw/rtl/ptmap_store.sv
hw/rtl/ptmap_walk.sv
hw/rtl/four_level_page_table_mapper.sv
tb/testbench.sv
